>>> rtl/core/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg
// shared widths, request codes and status codes of the slot table
// ----------------------------------------------------------------------------
package ist_pkg;

  // payload field widths
  localparam int REQ_W     = 3;
  localparam int IDX_W     = 8;
  localparam int ITEM_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int RIDX_W    = 4;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 5;

  // default configuration
  localparam int CAPACITY_DEF   = 16;
  localparam int WORD_WIDTH_DEF = 32;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_GET    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

endpackage

>>> rtl/core/ist_if.sv
// ----------------------------------------------------------------------------
// ist_in_if / ist_out_if
// request and response channels of the slot table, valid/ready handshake
// ----------------------------------------------------------------------------
interface ist_in_if;
  import ist_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [IDX_W-1:0]    slot_index;
  logic [ITEM_W-1:0]   item_value;

  modport source (output valid, output req_type, output slot_index, output item_value,
                  input ready);
  modport sink   (input valid, input req_type, input slot_index, input item_value,
                  output ready);
endinterface

interface ist_out_if;
  import ist_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [RIDX_W-1:0]     result_index;
  logic [VAL_W-1:0]      result_value;
  logic [CNT_OUT_W-1:0]  occupied_count;

  modport source (output valid, output status, output result_index, output result_value,
                  output occupied_count, input ready);
  modport sink   (input valid, input status, input result_index, input result_value,
                  input occupied_count, output ready);
endinterface

>>> rtl/core/ist_ram.sv
// ----------------------------------------------------------------------------
// ist_ram
// single-port synchronous ram, registered read with read enable
// ----------------------------------------------------------------------------
module ist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/ist_first_free.sv
// ----------------------------------------------------------------------------
// ist_first_free
// priority encoder: lowest slot whose occupied flag is clear
// ----------------------------------------------------------------------------
module ist_first_free #(
  parameter int CAPACITY = 16
) (
  input  logic [CAPACITY-1:0]         busy,
  output logic                        found,
  output logic [$clog2(CAPACITY)-1:0] idx
);

  localparam int AW = $clog2(CAPACITY);

  // scan from the top so the lowest free slot wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        found = 1'b1;
        idx   = AW'(i);
      end
    end
  end

endmodule

>>> rtl/core/indexed_slot_table.sv
// ----------------------------------------------------------------------------
// indexed_slot_table
// flow: an accepted request waits in the pending registers while the slot word
//   ram read completes, then loads into the response register once that register
//   is free; no new request is taken until the response register has loaded
// reset: synchronous active-low; all slots empty and count zero at once,
//   slot word ram contents left as they are
// ----------------------------------------------------------------------------
module indexed_slot_table #(
  parameter int CAPACITY   = ist_pkg::CAPACITY_DEF,
  parameter int WORD_WIDTH = ist_pkg::WORD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ist_in_if.sink    in_ch,
  ist_out_if.source out_ch
);
  import ist_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W:0] CAP_EXT = (IDX_W + 1)'(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  // control state
  state_t               state_r;
  logic [CAPACITY-1:0]  valid_r;
  logic [CNT_W-1:0]     count_r;
  logic                 out_valid_r;

  // request held while the ram read completes
  logic [STATUS_W-1:0]  pend_status_r;
  logic [RIDX_W-1:0]    pend_ridx_r;
  logic                 pend_read_r;

  // response register
  logic [STATUS_W-1:0]  out_status_r;
  logic [RIDX_W-1:0]    out_ridx_r;
  logic [VAL_W-1:0]     out_value_r;
  logic [CNT_OUT_W-1:0] out_count_r;

  // next values
  logic [CAPACITY-1:0]  valid_nxt;
  logic [CNT_W-1:0]     count_nxt;
  logic [STATUS_W-1:0]  status_nxt;
  logic [RIDX_W-1:0]    ridx_nxt;
  logic                 read_nxt;

  // decode helpers
  logic                 in_fire;
  logic                 in_range;
  logic [AW-1:0]        idx_a;
  logic                 slot_full;
  logic                 free_found;
  logic [AW-1:0]        free_idx;
  logic [IDX_W-1:0]     free_idx8;
  logic                 load_out;

  // ram port
  logic                  ram_we;
  logic                  ram_re;
  logic [AW-1:0]         ram_addr;
  logic [WORD_WIDTH-1:0] ram_wdata;
  logic [WORD_WIDTH-1:0] ram_rdata;

  // one request in flight at a time; the response register frees the input side
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign idx_a     = in_ch.slot_index[AW-1:0];
  assign in_range  = {1'b0, in_ch.slot_index} < CAP_EXT;
  assign slot_full = valid_r[idx_a];
  assign free_idx8 = IDX_W'(free_idx);
  assign ram_wdata = WORD_WIDTH'(in_ch.item_value);

  ist_first_free #(
    .CAPACITY (CAPACITY)
  ) u_first_free (
    .busy  (valid_r),
    .found (free_found),
    .idx   (free_idx)
  );

  ist_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (CAPACITY)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // request decode: flags and count are registered on accept, and the word
  // is written or read on accept too, its read data held for the response
  always_comb begin
    valid_nxt  = valid_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    ridx_nxt   = in_ch.slot_index[RIDX_W-1:0];
    read_nxt   = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = idx_a;
    case (in_ch.req_type)
      REQ_INSERT: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end else begin
          ram_we           = in_fire;
          valid_nxt[idx_a] = 1'b1;
          if (!slot_full) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      REQ_GET: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end else if (!slot_full) begin
          status_nxt = ST_EMPTY;
        end else begin
          read_nxt = 1'b1;
          ram_re   = in_fire;
        end
      end
      REQ_REMOVE: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end else if (!slot_full) begin
          status_nxt = ST_EMPTY;
        end else begin
          read_nxt         = 1'b1;
          ram_re           = in_fire;
          valid_nxt[idx_a] = 1'b0;
          count_nxt        = count_r - CNT_W'(1);
        end
      end
      REQ_ADD: begin
        if (!free_found) begin
          status_nxt = ST_FULL;
          ridx_nxt   = '0;
        end else begin
          ram_we              = in_fire;
          ram_addr            = free_idx;
          valid_nxt[free_idx] = 1'b1;
          count_nxt           = count_r + CNT_W'(1);
          ridx_nxt            = free_idx8[RIDX_W-1:0];
        end
      end
      REQ_CLEAR: begin
        valid_nxt = '0;
        count_nxt = '0;
      end
      default: begin
        // unused codes leave the table untouched
      end
    endcase
  end

  // response loads once the previous one has left the register
  assign load_out = (state_r == S_RESP) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            valid_r       <= valid_nxt;
            count_r       <= count_nxt;
            pend_status_r <= status_nxt;
            pend_ridx_r   <= ridx_nxt;
            pend_read_r   <= read_nxt;
            state_r       <= S_RESP;
          end
        end
        S_RESP: begin
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      // response register; the ram read data holds until loaded
      if (load_out) begin
        out_valid_r  <= 1'b1;
        out_status_r <= pend_status_r;
        out_ridx_r   <= pend_ridx_r;
        out_value_r  <= pend_read_r ? VAL_W'(ram_rdata) : '0;
        out_count_r  <= CNT_OUT_W'(count_r);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.result_index   = out_ridx_r;
  assign out_ch.result_value   = out_value_r;
  assign out_ch.occupied_count = out_count_r;

  // running count always matches the occupied flags
  a_count_matches : assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(valid_r)))
    else $error("occupancy count out of step with slot flags");

  // a response only appears out of the ram read state
  a_resp_from_read : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("response raised without a pending request");

  // no request is taken while one waits on the ram read
  a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) |-> !in_ch.ready)
    else $error("request accepted during ram read");

  // an add that found a free slot leaves the occupancy count nonzero
  a_add_marks : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.req_type == REQ_ADD && free_found) |=> (count_r != '0))
    else $error("add left the table empty");

endmodule
